/* design/rffp_pkg.sv */
// ============================================================================
// rffp_pkg
// Shared types, layout constants and codes of the RTU frame field parser.
// ============================================================================
`default_nettype none

package rffp_pkg;

    // Layout parameters of the frame.
    localparam int DEVICE_ID_BYTES = 12;
    localparam int ANALOG_CHANNELS = 16;

    // Byte positions within a frame (position 0 is the header).
    localparam logic [6:0] POS_SERIAL    = 7'd1;
    localparam logic [6:0] POS_TARGET_LO = 7'd3;
    localparam logic [6:0] POS_INDEX_LO  = 7'd7;
    localparam logic [6:0] POS_DEV       = 7'd15;
    localparam logic [6:0] POS_LEN_HI    = 7'(15 + DEVICE_ID_BYTES);
    localparam logic [6:0] POS_LEN_LO    = 7'(16 + DEVICE_ID_BYTES);
    localparam logic [6:0] POS_DATA0     = 7'(17 + DEVICE_ID_BYTES);

    // Offsets within the data section.
    localparam logic [6:0] Q_SWITCH     = 7'd5;
    localparam logic [6:0] Q_PAD2       = 7'd8;
    localparam logic [6:0] Q_ANALOG     = 7'd10;
    localparam logic [6:0] Q_END        = 7'(10 + 2 * ANALOG_CHANNELS);
    localparam logic [6:0] Q_CKS_REPORT = 7'(11 + 2 * ANALOG_CHANNELS);
    localparam logic [6:0] Q_CKS_REG    = 7'd7;

    // Field identifiers; all but ID_FINAL are kept one bit wider and truncated on use.
    localparam logic [6:0] ID_SERIAL      = 7'd0;
    localparam logic [6:0] ID_TARGET      = 7'd1;
    localparam logic [6:0] ID_DEV_BASE    = 7'd4;
    localparam logic [6:0] ID_LENGTH      = 7'(4 + DEVICE_ID_BYTES);
    localparam logic [6:0] ID_DATA_BASE   = 7'(5 + DEVICE_ID_BYTES);
    localparam logic [6:0] ID_ANALOG_BASE = 7'(8 + DEVICE_ID_BYTES);
    localparam logic [5:0] ID_FINAL       = 6'd47;

    localparam logic [15:0] LEN_REGISTER = 16'd7;
    localparam logic [15:0] LEN_REPORT   = 16'd43;

    localparam logic [7:0] END_MARKER_RESET = 8'h0A;

    // Request queue between the front and back parts.
    localparam int QPTR_W      = 2;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_UNKNOWN_LEN = 3'd1,
        ST_BAD_END     = 3'd2,
        ST_CKS_BAD     = 3'd3,
        ST_TRUNC       = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_RESTART,
        OP_SKIP,
        OP_LATCH,
        OP_BYTE,
        OP_WORD,
        OP_CHECK,
        OP_TAIL
    } t_op;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  field_id;
        logic [15:0] field_value;
        logic        frame_kind;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

    // One classified byte, handed from the front to the back.
    typedef struct packed {
        t_op        op;
        logic [5:0] field_id;
        logic [7:0] data_byte;
        logic       kind;
        t_status    status;
        logic       last;
    } t_qentry;

endpackage

`default_nettype wire

/* design/rffp_front.sv */
// ============================================================================
// rffp_front
// Tracks the frame position and classifies each byte of an open frame into a back-end request.
// ============================================================================
`default_nettype none

module rffp_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [7:0]         i_cfg_data,
    input  wire                i_accept,
    input  rffp_pkg::t_in_item i_item,
    output logic               o_push,
    output rffp_pkg::t_qentry  o_entry
);
    import rffp_pkg::*;

    logic [7:0] r_end_marker;
    logic       r_active;
    logic [6:0] r_pos;
    logic       r_kind;
    logic [7:0] r_len_hi;

    logic       n_active;
    logic [6:0] n_pos;
    logic       n_kind;
    logic [7:0] n_len_hi;

    logic [6:0]  w_q;
    logic [6:0]  w_r;
    logic [6:0]  w_cks;
    logic [7:0]  w_b;
    logic [15:0] w_length;

    assign w_b      = i_item.data_byte;
    assign w_q      = r_pos - POS_DATA0;
    assign w_r      = w_q - Q_ANALOG;
    assign w_cks    = r_kind ? Q_CKS_REPORT : Q_CKS_REG;
    assign w_length = {r_len_hi, w_b};

    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        n_kind   = r_kind;
        n_len_hi = r_len_hi;
        o_push   = 1'b0;
        o_entry  = '{op: OP_SKIP, field_id: 6'd0, data_byte: w_b, kind: 1'b0,
                     status: ST_OK, last: 1'b0};

        if (i_accept && i_item.frame_start) begin
            o_push        = 1'b1;
            o_entry.op    = r_active ? OP_RESTART : OP_CLEAR;
            o_entry.kind  = r_kind;
            n_active      = 1'b1;
            n_pos         = 7'd1;
            n_kind        = 1'b0;
            n_len_hi      = 8'd0;
        end else if (i_accept && r_active) begin
            o_push = 1'b1;
            n_pos  = r_pos + 7'd1;
            if (r_pos < POS_DATA0) begin
                if (r_pos == POS_SERIAL) begin
                    o_entry.op       = OP_BYTE;
                    o_entry.field_id = ID_SERIAL[5:0];
                end else if (r_pos inside {7'd2, 7'd4, 7'd6}) begin
                    o_entry.op = OP_LATCH;
                end else if (r_pos inside {[POS_TARGET_LO:POS_INDEX_LO]}) begin
                    o_entry.op       = OP_WORD;
                    o_entry.field_id = 6'(ID_TARGET + ((r_pos - POS_TARGET_LO) >> 1));
                end else if (r_pos >= POS_DEV && r_pos < POS_LEN_HI) begin
                    o_entry.op       = OP_BYTE;
                    o_entry.field_id = 6'(ID_DEV_BASE + (r_pos - POS_DEV));
                end else if (r_pos == POS_LEN_HI) begin
                    o_entry.op = OP_LATCH;
                    n_len_hi   = w_b;
                end else if (r_pos == POS_LEN_LO) begin
                    o_entry.op       = OP_WORD;
                    o_entry.field_id = ID_LENGTH[5:0];
                    if (w_length == LEN_REGISTER) begin
                        n_kind = 1'b0;
                    end else if (w_length == LEN_REPORT) begin
                        n_kind = 1'b1;
                    end else begin
                        n_kind         = 1'b0;
                        n_active       = 1'b0;
                        o_entry.status = ST_UNKNOWN_LEN;
                        o_entry.last   = 1'b1;
                    end
                    o_entry.kind = n_kind;
                end
            end else begin
                o_entry.kind = r_kind;
                if (w_q == w_cks) begin
                    o_entry.op = OP_CHECK;
                end else if (w_q > w_cks) begin
                    o_entry.op = OP_TAIL;
                    n_active   = 1'b0;
                end else if (!r_kind) begin
                    o_entry.op       = OP_BYTE;
                    o_entry.field_id = 6'(ID_DATA_BASE + w_q);
                end else if (w_q < Q_SWITCH) begin
                    o_entry.op = OP_SKIP;
                end else if (w_q < Q_PAD2) begin
                    o_entry.op       = OP_BYTE;
                    o_entry.field_id = 6'(ID_DATA_BASE + (w_q - Q_SWITCH));
                end else if (w_q < Q_ANALOG) begin
                    o_entry.op = OP_SKIP;
                end else if (w_q < Q_END) begin
                    if (!w_r[0]) begin
                        o_entry.op = OP_LATCH;
                    end else begin
                        o_entry.op       = OP_WORD;
                        o_entry.field_id = 6'(ID_ANALOG_BASE + (w_r >> 1));
                    end
                end else if (w_b != r_end_marker) begin
                    // Wrong end marker: report it and drop the rest of the frame.
                    o_entry.op       = OP_BYTE;
                    o_entry.field_id = ID_FINAL;
                    o_entry.status   = ST_BAD_END;
                    o_entry.last     = 1'b1;
                    n_active         = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_marker <= END_MARKER_RESET;
            r_active     <= 1'b0;
            r_pos        <= 7'd0;
            r_kind       <= 1'b0;
            r_len_hi     <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_end_marker <= i_cfg_data;
            end
            r_active <= n_active;
            r_pos    <= n_pos;
            r_kind   <= n_kind;
            r_len_hi <= n_len_hi;
        end
    end

endmodule

`default_nettype wire

/* design/rffp_queue.sv */
// ============================================================================
// rffp_queue
// Short first-in first-out queue of classified requests.
// ============================================================================
`default_nettype none

module rffp_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  rffp_pkg::t_qentry i_entry,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_empty,
    output rffp_pkg::t_qentry o_head
);
    import rffp_pkg::*;

    t_qentry           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/rffp_back.sv */
// ============================================================================
// rffp_back
// Carries out queued requests: checksum, word assembly and result register.
// ============================================================================
`default_nettype none

module rffp_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_has_entry,
    input  rffp_pkg::t_qentry   i_entry,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output rffp_pkg::t_out_item o_out_data
);
    import rffp_pkg::*;

    logic [7:0] r_sum;
    logic [7:0] r_hi;
    t_status    r_pend;
    logic       r_out_valid;
    t_out_item  r_out_data;

    logic w_emits;
    logic w_out_free;
    logic [7:0] w_b;

    assign w_b        = i_entry.data_byte;
    assign w_emits    = (i_entry.op inside {OP_RESTART, OP_BYTE, OP_WORD, OP_TAIL});
    assign w_out_free = !r_out_valid || i_out_ready;
    // Requests that produce no result never wait on the output side.
    assign o_pop      = i_has_entry && (!w_emits || w_out_free);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= 8'd0;
            r_hi        <= 8'd0;
            r_pend      <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (w_emits) begin
                    r_out_valid <= 1'b1;
                end
                case (i_entry.op)
                    OP_CLEAR: begin
                        r_sum  <= 8'd0;
                        r_hi   <= 8'd0;
                        r_pend <= ST_OK;
                    end
                    OP_RESTART: begin
                        r_out_data <= '{field_id: ID_FINAL, field_value: 16'd0,
                                        frame_kind: i_entry.kind, status: ST_TRUNC,
                                        last: 1'b1};
                        r_sum  <= 8'd0;
                        r_hi   <= 8'd0;
                        r_pend <= ST_OK;
                    end
                    OP_SKIP: begin
                        r_sum <= r_sum + w_b;
                    end
                    OP_LATCH: begin
                        r_sum <= r_sum + w_b;
                        r_hi  <= w_b;
                    end
                    OP_BYTE: begin
                        r_sum      <= r_sum + w_b;
                        r_out_data <= '{field_id: i_entry.field_id,
                                        field_value: {8'd0, w_b},
                                        frame_kind: i_entry.kind,
                                        status: i_entry.status,
                                        last: i_entry.last};
                    end
                    OP_WORD: begin
                        r_sum      <= r_sum + w_b;
                        r_out_data <= '{field_id: i_entry.field_id,
                                        field_value: {r_hi, w_b},
                                        frame_kind: i_entry.kind,
                                        status: i_entry.status,
                                        last: i_entry.last};
                    end
                    OP_CHECK: begin
                        r_hi   <= w_b;
                        r_pend <= (r_sum == w_b) ? ST_OK : ST_CKS_BAD;
                    end
                    OP_TAIL: begin
                        r_out_data <= '{field_id: ID_FINAL, field_value: {8'd0, r_hi},
                                        frame_kind: i_entry.kind, status: r_pend,
                                        last: 1'b1};
                    end
                    default: begin
                        r_sum <= r_sum;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* design/rtu_frame_field_parser_unit.sv */
// ============================================================================
// rtu_frame_field_parser_unit
// Byte-serial decoder of an RTU telemetry frame with one result per field.
// ============================================================================
//
// Channel   Direction  Handshake                   Payload
// -------   ---------  --------------------------  ---------------------------
// input     in         i_in_valid / o_in_ready     i_in_data  (byte, start)
// output    out        o_out_valid / i_out_ready   o_out_data (id, value, ...)
// config    in         i_cfg_we (no wait)          i_cfg_data (end marker)
//
// The block takes one byte request per cycle while the queue is not full. The
// front stage classifies the byte in the cycle it is accepted and writes it
// into a four-entry queue; the back stage retires one queued request per cycle
// unless the output stalls it, and each result passes from the queue into the
// output register. The sustained rate of one byte per cycle is set by the
// position step in the front and the checksum add in the back. A stalled
// output only holds requests that produce a result; the queue absorbs up to
// four bytes before the input stalls. Synchronous reset returns the parser to
// idle and the end marker to its default value.
//
`default_nettype none

module rtu_frame_field_parser_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [7:0]          i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  rffp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output rffp_pkg::t_out_item o_out_data
);
    import rffp_pkg::*;

    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    logic    w_accept;
    t_qentry w_push_entry;
    t_qentry w_head;

    // The front never stalls on its own; only a full queue holds off a request.
    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    rffp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_item     (i_in_data),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    rffp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    rffp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_has_entry (!w_empty),
        .i_entry     (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The queue can never look full and empty at once.
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_full && w_empty))
        else $error("request queue reports full and empty together");

    // A pushed request is visible in the queue on the next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_empty)
        else $error("pushed request did not reach the queue");

    // Any error or final status closes the frame.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |-> o_out_data.last)
        else $error("non-zero status on a result that is not last");

    // Only the final result or an unknown length ends a frame.
    a_last_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |->
            ((o_out_data.field_id == ID_FINAL) ||
             (o_out_data.status == ST_UNKNOWN_LEN)))
        else $error("last result with unexpected field id");

endmodule

`default_nettype wire
